/* sv/mqsfc_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-queue send flow control package
// Shared codes, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsfc_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_PERMIT = 2'd1;
	localparam logic [1:0] OP_ACK    = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	// Result kinds.
	localparam logic [2:0] KIND_SEND  = 3'd0;
	localparam logic [2:0] KIND_RTS   = 3'd1;
	localparam logic [2:0] KIND_MORE  = 3'd2;
	localparam logic [2:0] KIND_DONE  = 3'd3;
	localparam logic [2:0] KIND_ABORT = 3'd4;
	localparam logic [2:0] KIND_FULL  = 3'd5;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRIORITY_BASE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TIMEOUTS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRANT_TIMEOUT = 2'd3;

	localparam int WEIGHT_W = 16;
	localparam int BASE_W   = 5;

	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] queue_index;
		logic [5:0] max_packets;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] queue_sel;
		logic [5:0] packet_count;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic permit_init;
		logic pop_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       out_free;
		logic       total_zero;
		logic       burst_done;
	} status_t;

endpackage

`default_nettype wire

/* sv/mqsfc_weights.sv */
// ----------------------------------------------------------------------------
// Weight generator
// Computes the round-robin weights base^(N-1-j), saturated to 16 bits, one
// queue per cycle with a shared multiplier, starting from the lowest priority.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsfc_weights #(
	parameter int NUM_QUEUES = 4
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           start,
	input  wire logic [mqsfc_pkg::BASE_W-1:0]                   base,
	output logic      [NUM_QUEUES-1:0][mqsfc_pkg::WEIGHT_W-1:0] weights,
	output logic                                                busy
);

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PROD_W = mqsfc_pkg::WEIGHT_W + mqsfc_pkg::BASE_W;

	logic [NUM_QUEUES-1:0][mqsfc_pkg::WEIGHT_W-1:0] weights_q;
	logic [mqsfc_pkg::WEIGHT_W-1:0]                 acc_q;
	logic [QW-1:0]                                  idx_q;
	logic                                           busy_q;
	logic [PROD_W-1:0]                              prod;
	logic [mqsfc_pkg::WEIGHT_W-1:0]                 prod_sat;

	assign prod = PROD_W'(acc_q) * PROD_W'(base);
	assign prod_sat = (|prod[PROD_W-1:mqsfc_pkg::WEIGHT_W]) ?
		{mqsfc_pkg::WEIGHT_W{1'b1}} : prod[mqsfc_pkg::WEIGHT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				weights_q[i] <= mqsfc_pkg::WEIGHT_W'(1);
			end
			busy_q <= 1'b0;
		end else if (start) begin
			weights_q[NUM_QUEUES-1] <= mqsfc_pkg::WEIGHT_W'(1);
			busy_q <= (NUM_QUEUES > 1);
		end else if (busy_q) begin
			weights_q[idx_q] <= prod_sat;
			if (idx_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= mqsfc_pkg::WEIGHT_W'(1);
			idx_q <= QW'((NUM_QUEUES > 1) ? NUM_QUEUES - 2 : 0);
		end else if (busy_q) begin
			acc_q <= prod_sat;
			idx_q <= idx_q - 1'b1;
		end
	end

	assign weights = weights_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

/* sv/mqsfc_ctrl.sv */
// ----------------------------------------------------------------------------
// Flow control sequencer
// Accepts one transaction at a time and steps the datapath through decode,
// packet selection and the closing report of a permit.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsfc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                wgt_busy,
	input  wire mqsfc_pkg::status_t  status,
	output mqsfc_pkg::cmd_t          cmd
);

	mqsfc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqsfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mqsfc_pkg::ST_IDLE: begin
				in_ready = !wgt_busy;
				if (in_valid && !wgt_busy) begin
					cmd.load = 1'b1;
					state_d  = mqsfc_pkg::ST_DECODE;
				end
			end
			mqsfc_pkg::ST_DECODE: begin
				if (status.op == mqsfc_pkg::OP_PERMIT) begin
					cmd.permit_init = 1'b1;
					state_d         = mqsfc_pkg::ST_POP;
				end else if (status.out_free) begin
					cmd.exec = 1'b1;
					state_d  = mqsfc_pkg::ST_IDLE;
				end
			end
			mqsfc_pkg::ST_POP: begin
				if (status.burst_done || status.total_zero) begin
					state_d = mqsfc_pkg::ST_FINISH;
				end else if (status.out_free) begin
					cmd.pop_step = 1'b1;
				end
			end
			mqsfc_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = mqsfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mqsfc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/mqsfc_dpath.sv */
// ----------------------------------------------------------------------------
// Flow control datapath
// Queue fill counters, arbitration pointer, retry timer, configuration
// registers and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsfc_dpath #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_DEPTH = 64,
	parameter int MAX_BURST   = 32
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           cfg_wr_en,
	input  wire logic [mqsfc_pkg::CFG_INDEX_W-1:0]              cfg_index,
	input  wire logic [mqsfc_pkg::CFG_DATA_W-1:0]               cfg_data,
	input  wire mqsfc_pkg::in_item_t                            in_data,
	input  wire mqsfc_pkg::cmd_t                                cmd,
	output mqsfc_pkg::status_t                                  status,
	input  wire logic [NUM_QUEUES-1:0][mqsfc_pkg::WEIGHT_W-1:0] weights,
	output logic                                                wgt_start,
	output logic      [mqsfc_pkg::BASE_W-1:0]                   base,
	output logic                                                out_valid,
	input  wire logic                                           out_ready,
	output mqsfc_pkg::out_item_t                                out_data
);

	localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TOT_W  = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
	localparam int WW     = mqsfc_pkg::WEIGHT_W;

	// Configuration registers.
	logic [mqsfc_pkg::BASE_W-1:0] base_q;
	logic [7:0]                   max_to_q;
	logic [15:0]                  ack_to_q;
	logic [15:0]                  grant_to_q;

	// Latched transaction.
	logic [1:0] op_q;
	logic [1:0] qi_q;
	logic [5:0] allow_q;
	logic [5:0] sent_q, sent_d;

	// Flow control state.
	logic [NUM_QUEUES-1:0][FILL_W-1:0] fill_q;
	logic [TOT_W-1:0]                  total_q, total_d;
	logic [QW-1:0]                     cur_q, cur_d;
	logic [WW-1:0]                     run_q, run_d;
	logic                              armed_q, armed_d;
	logic [15:0]                       left_q, left_d;
	logic [7:0]                        tmo_q, tmo_d;

	logic                 out_valid_q;
	mqsfc_pkg::out_item_t out_data_q;

	logic                 emit;
	mqsfc_pkg::out_item_t emit_item;
	logic                 fill_inc, fill_dec, fill_clr;
	logic [QW-1:0]        qi_idx, pop_idx, rd_idx;
	logic [FILL_W-1:0]    rd_fill;
	logic                 push_bad;
	logic [7:0]           tmo_next;
	logic [WW:0]          run_inc;

	function automatic logic [QW-1:0] next_idx(input logic [QW-1:0] q);
		return (q == QW'(NUM_QUEUES - 1)) ? '0 : q + 1'b1;
	endfunction

	assign qi_idx  = QW'(qi_q);
	assign pop_idx = (base_q != '0) ? cur_q : next_idx(cur_q);
	assign rd_idx  = (op_q == mqsfc_pkg::OP_PERMIT) ? pop_idx : qi_idx;
	assign rd_fill = fill_q[rd_idx];

	assign push_bad = (32'(qi_q) >= NUM_QUEUES) || (rd_fill >= FILL_W'(QUEUE_DEPTH));
	assign tmo_next = (tmo_q != 8'hFF) ? tmo_q + 1'b1 : tmo_q;
	assign run_inc  = {1'b0, run_q} + 1'b1;

	assign wgt_start = cfg_wr_en && (cfg_index == mqsfc_pkg::CFG_PRIORITY_BASE);
	assign base      = base_q;

	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		fill_inc  = 1'b0;
		fill_dec  = 1'b0;
		fill_clr  = 1'b0;
		total_d   = total_q;
		cur_d     = cur_q;
		run_d     = run_q;
		armed_d   = armed_q;
		left_d    = left_q;
		tmo_d     = tmo_q;
		sent_d    = sent_q;

		if (cmd.exec) begin
			unique case (op_q)
				mqsfc_pkg::OP_PUSH: begin
					if (push_bad) begin
						emit                = 1'b1;
						emit_item.kind      = mqsfc_pkg::KIND_FULL;
						emit_item.queue_sel = qi_q;
						emit_item.last      = 1'b1;
					end else begin
						fill_inc = 1'b1;
						total_d  = total_q + 1'b1;
						if (total_q == '0) begin
							armed_d        = 1'b1;
							left_d         = ack_to_q;
							emit           = 1'b1;
							emit_item.kind = mqsfc_pkg::KIND_RTS;
							emit_item.last = 1'b1;
						end
					end
				end
				mqsfc_pkg::OP_ACK: begin
					if (armed_q) begin
						left_d = grant_to_q;
					end
				end
				mqsfc_pkg::OP_TICK: begin
					if (armed_q) begin
						if (left_q <= 16'd1) begin
							emit           = 1'b1;
							emit_item.last = 1'b1;
							if ((max_to_q != '0) && (tmo_next >= max_to_q)) begin
								// Retry limit reached: give up and drop every queued packet.
								tmo_d          = '0;
								armed_d        = 1'b0;
								left_d         = '0;
								fill_clr       = 1'b1;
								total_d        = '0;
								emit_item.kind = mqsfc_pkg::KIND_ABORT;
							end else begin
								tmo_d          = tmo_next;
								armed_d        = 1'b1;
								left_d         = ack_to_q;
								emit_item.kind = mqsfc_pkg::KIND_RTS;
							end
						end else begin
							left_d = left_q - 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (cmd.permit_init) begin
			armed_d = 1'b0;
			left_d  = '0;
			sent_d  = '0;
		end

		if (cmd.pop_step) begin
			if (base_q != '0) begin
				// Weighted: stay on a queue until it has sent its weight or runs dry.
				if (rd_fill == '0) begin
					run_d = '0;
					cur_d = next_idx(cur_q);
				end else begin
					if (run_inc >= {1'b0, weights[cur_q]}) begin
						run_d = '0;
						cur_d = next_idx(cur_q);
					end else begin
						run_d = run_inc[WW-1:0];
					end
					fill_dec = 1'b1;
				end
			end else begin
				cur_d = pop_idx;
				if (rd_fill != '0) begin
					fill_dec = 1'b1;
				end
			end
			if (fill_dec) begin
				total_d             = total_q - 1'b1;
				sent_d              = sent_q + 1'b1;
				emit                = 1'b1;
				emit_item.kind      = mqsfc_pkg::KIND_SEND;
				emit_item.queue_sel = 2'(rd_idx);
			end
		end

		if (cmd.finish) begin
			emit                   = 1'b1;
			emit_item.packet_count = sent_q;
			emit_item.last         = 1'b1;
			tmo_d                  = '0;
			if (total_q != '0) begin
				armed_d        = 1'b1;
				left_d         = ack_to_q;
				emit_item.kind = mqsfc_pkg::KIND_MORE;
			end else begin
				emit_item.kind = mqsfc_pkg::KIND_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			max_to_q   <= '0;
			ack_to_q   <= 16'd10;
			grant_to_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mqsfc_pkg::CFG_PRIORITY_BASE: base_q <= cfg_data[mqsfc_pkg::BASE_W-1:0];
				mqsfc_pkg::CFG_MAX_TIMEOUTS:  max_to_q <= cfg_data[7:0];
				mqsfc_pkg::CFG_ACK_TIMEOUT:   ack_to_q <= cfg_data;
				mqsfc_pkg::CFG_GRANT_TIMEOUT: grant_to_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			total_q     <= '0;
			cur_q       <= '0;
			run_q       <= '0;
			armed_q     <= 1'b0;
			left_q      <= '0;
			tmo_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				if (fill_clr) begin
					fill_q[i] <= '0;
				end else if (fill_inc && (rd_idx == QW'(i))) begin
					fill_q[i] <= fill_q[i] + 1'b1;
				end else if (fill_dec && (rd_idx == QW'(i))) begin
					fill_q[i] <= fill_q[i] - 1'b1;
				end
			end
			total_q <= total_d;
			cur_q   <= cur_d;
			run_q   <= run_d;
			armed_q <= armed_d;
			left_q  <= left_d;
			tmo_q   <= tmo_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_data.opcode;
			qi_q    <= in_data.queue_index;
			allow_q <= (in_data.max_packets > 6'(MAX_BURST)) ? 6'(MAX_BURST) :
				in_data.max_packets;
		end
		sent_q <= sent_d;
		if (emit) begin
			out_data_q <= emit_item;
		end
	end

	assign status.op         = op_q;
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.total_zero = (total_q == '0);
	assign status.burst_done = (sent_q >= allow_q);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

/* sv/multi_queue_send_flow_control_unit.sv */
// ----------------------------------------------------------------------------
// Multi-queue send flow control unit
// Sender side of a request-to-send flow control over several priority queues.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A push, acknowledge or tick is
// accepted, then decoded and applied, plus any wait for the output
// register to drain. A permit is accepted, then set up, then the arbiter
// examines one queue per step: a packet is sent on each step that finds
// data under the pointer, and up to NUM_QUEUES-1 empty queues may be passed
// over before a packet. A further step sees that the burst has ended
// and a last step issues the closing send-more or completed result. Every
// step that issues a result also waits while the output register holds a
// result that has not been taken, so the sequencer issues at most one result
// per cycle. Writing priority_base restarts the weight generator, which
// shares one multiplier across queues and holds off input while it runs.
// No clearing pass is needed after reset.
`default_nettype none

module multi_queue_send_flow_control_unit #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_DEPTH = 64,
	parameter int MAX_BURST   = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [mqsfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mqsfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire mqsfc_pkg::in_item_t               in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output mqsfc_pkg::out_item_t                   out_data
);

	mqsfc_pkg::cmd_t    cmd;
	mqsfc_pkg::status_t status;
	logic                                           wgt_start;
	logic                                           wgt_busy;
	logic [mqsfc_pkg::BASE_W-1:0]                   base;
	logic [NUM_QUEUES-1:0][mqsfc_pkg::WEIGHT_W-1:0] weights;

	mqsfc_weights #(
		.NUM_QUEUES(NUM_QUEUES)
	) u_weights (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (wgt_start),
		.base    (base),
		.weights (weights),
		.busy    (wgt_busy)
	);

	mqsfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.wgt_busy (wgt_busy),
		.status   (status),
		.cmd      (cmd)
	);

	mqsfc_dpath #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_BURST   (MAX_BURST)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.weights   (weights),
		.wgt_start (wgt_start),
		.base      (base),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* sv/mqsfc_checker.sv */
// ----------------------------------------------------------------------------
// Multi-queue send flow control checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsfc_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire mqsfc_pkg::out_item_t out_data
);

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One transaction is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// Only packet selections are followed by more results of the same transaction.
	a_last_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.kind == mqsfc_pkg::KIND_SEND) == !out_data.last))
		else $error("last flag does not match result kind");

	// Packet counts appear only on the closing report of a permit.
	a_count_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind != mqsfc_pkg::KIND_MORE)
			&& (out_data.kind != mqsfc_pkg::KIND_DONE)
		|-> (out_data.packet_count == '0))
		else $error("packet count on a result that carries none");

endmodule

bind multi_queue_send_flow_control_unit mqsfc_checker u_mqsfc_checker (.*);

`default_nettype wire
